// File: src/mhpq_pkg.sv
// Shared types and constants of the min-heap priority queue.
package mhpq_pkg;

    localparam int KEY_W       = 32;
    localparam int STAT_W      = 2;
    localparam int OCC_W       = 7;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - KEY_W - STAT_W - OCC_W;

    typedef enum logic [0:0] {
        REQ_INSERT  = 1'b0,
        REQ_EXTRACT = 1'b1
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        RES_INSERTED  = 2'd0,
        RES_EXTRACTED = 2'd1,
        RES_EMPTY     = 2'd2,
        RES_FULL      = 2'd3
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_EXT_MIN,
        ST_EXT_LOAD,
        ST_DN_CHK,
        ST_DN_LEFT,
        ST_DN_CMP,
        ST_PUSH
    } state_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_ROOT,
        RD_PARENT,
        RD_LAST,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_KEY,
        WR_UP,
        WR_CHILD
    } wr_sel_t;

    typedef struct packed {
        logic    ins_start;
        logic    ext_start;
        logic    load_key;
        logic    lval_load;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    set_res;
        res_t    res_code;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic full;
        logic at_root;
        logic up_swap;
        logic left_in;
        logic down_swap;
    } sts_t;

endpackage

// File: src/mhpq_dp.sv
// Datapath of the min-heap priority queue: heap memory, count, index and key registers.
module mhpq_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [mhpq_pkg::KEY_W-1:0]    key_in,
    input  mhpq_pkg::cmd_t                       cmd,
    output mhpq_pkg::sts_t                       sts,
    output logic [mhpq_pkg::OUT_TDATA_W-1:0]     out_data
);
    import mhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [KEY_W-1:0] mem [CAPACITY];

    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] lval_reg, lval_next;
    logic signed [KEY_W-1:0] rdata_reg;
    logic signed [KEY_W-1:0] res_key_reg, res_key_next;
    res_t                    res_code_reg, res_code_next;
    logic [OUT_TDATA_W-1:0]  out_data_reg, out_data_next;

    logic [AW-1:0]           parent_idx;
    logic [AW+1:0]           left_idx;
    logic [AW+1:0]           right_idx;
    logic [AW+1:0]           count_ext;
    logic                    right_in;
    logic                    right_sel;
    logic signed [KEY_W-1:0] child_val;
    logic [AW-1:0]           child_idx;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [KEY_W-1:0] wr_data;

    assign parent_idx = (idx_reg - AW'(1)) >> 1;
    assign left_idx   = (AW + 2)'({idx_reg, 1'b1});
    assign right_idx  = left_idx + (AW + 2)'(1);
    assign count_ext  = (AW + 2)'(count_reg);
    assign right_in   = right_idx < count_ext;
    // The right child wins only when strictly smaller; ties stay with the left child.
    assign right_sel  = right_in && (rdata_reg < lval_reg);
    assign child_val  = right_sel ? rdata_reg : lval_reg;
    assign child_idx  = right_sel ? right_idx[AW-1:0] : left_idx[AW-1:0];

    always_comb
    begin
        sts.count_zero = (count_reg == '0);
        sts.count_one  = (count_reg == CW'(1));
        sts.full       = (count_reg == CW'(CAPACITY));
        sts.at_root    = (idx_reg == '0);
        sts.up_swap    = (rdata_reg > key_reg);
        sts.left_in    = (left_idx < count_ext);
        sts.down_swap  = (child_val < key_reg);
    end

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = '0;
        case (cmd.rd_sel)
            RD_ROOT:   rd_addr = '0;
            RD_PARENT: rd_addr = parent_idx;
            RD_LAST:   rd_addr = AW'(count_reg - CW'(1));
            RD_LEFT:   rd_addr = left_idx[AW-1:0];
            RD_RIGHT:  rd_addr = right_idx[AW-1:0];
            default:   rd_en   = 1'b0;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = idx_reg;
        wr_data = key_reg;
        case (cmd.wr_sel)
            WR_KEY:   wr_data = key_reg;
            WR_UP:    wr_data = rdata_reg;
            WR_CHILD: wr_data = child_val;
            default:  wr_en   = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        idx_next      = idx_reg;
        key_next      = key_reg;
        lval_next     = lval_reg;
        res_key_next  = res_key_reg;
        res_code_next = res_code_reg;
        out_data_next = out_data_reg;

        if (cmd.ins_start)
        begin
            key_next   = key_in;
            idx_next   = AW'(count_reg);
            count_next = count_reg + CW'(1);
        end
        if (cmd.ext_start)
        begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.load_key)
        begin
            key_next = rdata_reg;
            idx_next = '0;
        end
        if (cmd.lval_load)
        begin
            lval_next = rdata_reg;
        end
        if (cmd.wr_sel == WR_UP)
        begin
            idx_next = parent_idx;
        end
        if (cmd.wr_sel == WR_CHILD)
        begin
            idx_next = child_idx;
        end
        if (cmd.set_res)
        begin
            res_code_next = cmd.res_code;
            res_key_next  = (cmd.res_code == RES_EXTRACTED) ? rdata_reg : '0;
        end
        if (cmd.out_load)
        begin
            // Occupancy is reported modulo 128.
            out_data_next = {{OUT_PAD_W{1'b0}}, OCC_W'(count_reg), res_code_reg, res_key_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        key_reg      <= key_next;
        lval_reg     <= lval_next;
        res_key_reg  <= res_key_next;
        res_code_reg <= res_code_next;
        out_data_reg <= out_data_next;
    end

    assign out_data = out_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count exceeds capacity");
    a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_start |-> !sts.full)
        else $error("insert started on a full heap");
    a_ext_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ext_start |-> !sts.count_zero)
        else $error("extract started on an empty heap");
    a_child_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_sel == WR_CHILD) |-> sts.left_in)
        else $error("swap with a child that is not in the heap");
`endif

endmodule

// File: src/mhpq_ctrl.sv
// Controller state machine of the min-heap priority queue.
module mhpq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           req_type,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  mhpq_pkg::sts_t sts,
    output mhpq_pkg::cmd_t cmd
);
    import mhpq_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.rd_sel = RD_NONE;
        cmd.wr_sel = WR_NONE;
        cmd.res_code = RES_INSERTED;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (req_type == REQ_INSERT)
                    begin
                        if (sts.full)
                        begin
                            cmd.set_res  = 1'b1;
                            cmd.res_code = RES_FULL;
                            state_next   = ST_PUSH;
                        end
                        else
                        begin
                            cmd.ins_start = 1'b1;
                            state_next    = ST_INS_CHK;
                        end
                    end
                    else if (sts.count_zero)
                    begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = RES_EMPTY;
                        state_next   = ST_PUSH;
                    end
                    else
                    begin
                        cmd.rd_sel = RD_ROOT;
                        state_next = ST_EXT_MIN;
                    end
                end
            end
            ST_INS_CHK:
            begin
                if (sts.at_root)
                begin
                    cmd.wr_sel   = WR_KEY;
                    cmd.set_res  = 1'b1;
                    cmd.res_code = RES_INSERTED;
                    state_next   = ST_PUSH;
                end
                else
                begin
                    cmd.rd_sel = RD_PARENT;
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                if (sts.up_swap)
                begin
                    cmd.wr_sel = WR_UP;
                    state_next = ST_INS_CHK;
                end
                else
                begin
                    cmd.wr_sel   = WR_KEY;
                    cmd.set_res  = 1'b1;
                    cmd.res_code = RES_INSERTED;
                    state_next   = ST_PUSH;
                end
            end
            ST_EXT_MIN:
            begin
                cmd.set_res   = 1'b1;
                cmd.res_code  = RES_EXTRACTED;
                cmd.ext_start = 1'b1;
                if (sts.count_one)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    cmd.rd_sel = RD_LAST;
                    state_next = ST_EXT_LOAD;
                end
            end
            ST_EXT_LOAD:
            begin
                cmd.load_key = 1'b1;
                state_next   = ST_DN_CHK;
            end
            ST_DN_CHK:
            begin
                if (sts.left_in)
                begin
                    cmd.rd_sel = RD_LEFT;
                    state_next = ST_DN_LEFT;
                end
                else
                begin
                    cmd.wr_sel = WR_KEY;
                    state_next = ST_PUSH;
                end
            end
            ST_DN_LEFT:
            begin
                cmd.lval_load = 1'b1;
                cmd.rd_sel    = RD_RIGHT;
                state_next    = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                if (sts.down_swap)
                begin
                    cmd.wr_sel = WR_CHILD;
                    state_next = ST_DN_CHK;
                end
                else
                begin
                    cmd.wr_sel = WR_KEY;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    assign m_tvalid      = m_tvalid_reg;

`ifndef SYNTHESIS
    a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH && !out_free) |=> (state_reg == ST_PUSH))
        else $error("result dropped while the output was busy");
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in progress");
    a_load_after_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXT_LOAD) |-> ($past(state_reg) == ST_EXT_MIN))
        else $error("last element loaded outside an extract");
`endif

endmodule

// File: src/min_heap_priority_queue_unit.sv
// Top level of the min-heap priority queue: request and result streams around the core.
//
// This block is a binary min-heap of signed 32-bit keys held in an on-chip memory of CAPACITY
// entries. Each request on the slave stream either inserts s_tdata (s_tuser = 0) or extracts
// the smallest key (s_tuser = 1), and produces exactly one result on the master stream carrying
// the extracted key (zero unless extracted), a status code (inserted, extracted, empty on
// extract, full on insert) and the number of keys held afterward, modulo 128. Requests are
// worked one at a time; the heap memory has one read and one write port with a registered
// read, so each level of sift-up reads the parent and then compares and writes, and each level
// of sift-down reads the left child, then the right child, and then compares and writes. The
// next request is accepted in the same cycle as the result is first offered. The result sits
// in an output register, so the next request is accepted while the previous result still
// waits for m_tready. No clearing pass is needed after reset; the heap starts empty.
module min_heap_priority_queue_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // key_in [31:0]
    input  logic [mhpq_pkg::IN_TDATA_W-1:0]      s_tdata,
    // req_type [0]
    input  logic [mhpq_pkg::IN_TUSER_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // key_out [31:0], status [33:32], occupancy [40:34], zero padding [47:41]
    output logic [mhpq_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import mhpq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The controller sequences one request at a time through the datapath.
    mhpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the heap memory, the element count and the result register.
    mhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_in   ($signed(s_tdata[KEY_W-1:0])),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (m_tdata)
    );

endmodule
